// ===== sv/allocation_tracking_table_top_assert.svh =====
// Assertion macros for the allocation tracking table
`ifndef ALLOCATION_TRACKING_TABLE_TOP_ASSERT_SVH
`define ALLOCATION_TRACKING_TABLE_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define ATT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define ATT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/att_pkg.sv =====
`timescale 1ns / 1ps
package att_pkg;

    localparam int SLOTS      = 4096;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int OUT_SLOT_W = 12;
    localparam int ENTRY_W    = 1 + 3 * 64;

    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX2   = 64'h94d049bb133111eb;

    typedef enum logic [2:0] {
        OP_RECORD  = 3'd0,
        OP_RELEASE = 3'd1,
        OP_MOVE    = 3'd2,
        OP_READ    = 3'd3,
        OP_LOOKUP  = 3'd4,
        OP_CLEAR   = 3'd5
    } t_op;

    function automatic logic [63:0] mix_pre(input logic [63:0] a);
        logic [63:0] x;
        x = a + GOLDEN;
        return x ^ (x >> 30);
    endfunction

endpackage

// ===== sv/att_ram.sv =====
`timescale 1ns / 1ps
module att_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/allocation_tracking_table_top.sv =====
`timescale 1ns / 1ps
// Direct-mapped table of live allocations in one single-port RAM of SLOTS entries
// (valid, address, size, stamp). Each beat returns one result beat. The slot hash
// runs through one shared 32x32 multiplier that builds each 64-bit multiply from
// partial products. Record, release and lookup hash the address and then read the
// slot, which record and release may rewrite; move does two hashed read-modify-writes,
// read goes straight to the given slot, and clear writes one slot a cycle over all
// SLOTS entries. After reset the same clearing pass runs with s_axis_tready low.
// The next input beat is taken while a finished result still waits on the master side.
module allocation_tracking_table_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // address[63:0], old_address[127:64], alloc_size[191:128], stamp[255:192],
    // slot_index[267:256], zero pad
    input  logic [271:0] s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // recorded[0], released[1], slot[13:2], entry_valid[14], entry_address[78:15],
    // entry_size[142:79], entry_stamp[206:143], zero pad
    output logic [207:0] m_axis_tdata
);
    import att_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_HASH, S_RD, S_RDW, S_FIN, S_CLR} t_state;

    t_state               r_state;
    t_op                  r_op;
    logic [63:0]          r_addr, r_old, r_size, r_stamp;
    logic [63:0]          r_h, r_prod, r_acc;
    logic [1:0]           r_mstep;
    logic                 r_mpass, r_second, r_clr_op;
    logic [SLOT_BITS-1:0] r_slot, r_clr_cnt;
    logic                 r_rec, r_rel, r_val;
    logic [63:0]          r_ea, r_es, r_et;
    logic                 r_out_valid;
    logic [207:0]         r_out;

    logic [SLOT_BITS-1:0] ram_addr;
    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
    logic                 rd_v, key_hit, do_rel, do_rec, rel_phase;
    logic [63:0]          rd_a, rd_s, rd_t, key, z, mul_a, mul_b;

    att_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        {rd_v, rd_t, rd_s, rd_a} = ram_rdata;
        rel_phase = (r_op == OP_RELEASE) || (r_op == OP_MOVE && !r_second);
        key       = (r_op == OP_MOVE) ? r_old : r_addr;
        key_hit   = rd_v && (rd_a == key);
        do_rel    = (r_state == S_RDW) && rel_phase && key_hit;
        do_rec    = (r_state == S_RDW) && !rd_v && (r_addr != 64'd0)
                    && ((r_op == OP_RECORD) || (r_op == OP_MOVE && r_second));
        ram_we    = (r_state == S_CLR) || do_rel || do_rec;
        ram_addr  = (r_state == S_CLR) ? r_clr_cnt : r_slot;
        ram_wdata = do_rec ? {1'b1, r_stamp, r_size, r_addr} : '0;
        z         = r_acc + {r_prod[31:0], 32'd0};
        mul_a     = r_mpass ? MIX2 : MIX1;
        mul_b     = 64'(r_h[31:0]) * 64'(mul_a[31:0]);
        case (r_mstep)
            2'd1:    mul_b = 64'(r_h[31:0]) * 64'(mul_a[63:32]);
            2'd2:    mul_b = 64'(r_h[63:32]) * 64'(mul_a[31:0]);
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_clr_op    <= 1'b0;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
            r_mstep     <= '0;
            r_mpass     <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= t_op'(s_axis_tuser);
                        r_addr   <= s_axis_tdata[63:0];
                        r_old    <= s_axis_tdata[127:64];
                        r_size   <= s_axis_tdata[191:128];
                        r_stamp  <= s_axis_tdata[255:192];
                        r_second <= 1'b0;
                        r_mstep  <= '0;
                        r_mpass  <= 1'b0;
                        {r_rec, r_rel, r_val, r_ea, r_es, r_et} <= '0;
                        case (s_axis_tuser)
                            OP_RECORD, OP_RELEASE, OP_LOOKUP: begin
                                r_h     <= mix_pre(s_axis_tdata[63:0]);
                                r_state <= S_HASH;
                            end
                            OP_MOVE: begin
                                r_h     <= mix_pre(s_axis_tdata[127:64]);
                                r_state <= S_HASH;
                            end
                            OP_READ: begin
                                r_slot  <= SLOT_BITS'(s_axis_tdata[267:256]);
                                r_state <= S_RD;
                            end
                            OP_CLEAR: begin
                                r_slot    <= '0;
                                r_clr_cnt <= '0;
                                r_clr_op  <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            default: begin
                                r_slot  <= '0;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    r_prod  <= mul_b;
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == 2'd1) begin
                        r_acc <= r_prod;
                    end else if (r_mstep == 2'd2) begin
                        r_acc <= z;
                    end else if (r_mstep == 2'd3) begin
                        if (!r_mpass) begin
                            r_h     <= z ^ (z >> 27);
                            r_mpass <= 1'b1;
                        end else begin
                            r_slot  <= SLOT_BITS'(z ^ (z >> 31));
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    if (r_op == OP_MOVE && !r_second) begin
                        r_rel    <= key_hit;
                        r_second <= 1'b1;
                        r_h      <= mix_pre(r_addr);
                        r_mstep  <= '0;
                        r_mpass  <= 1'b0;
                        r_state  <= S_HASH;
                    end else begin
                        r_state <= S_FIN;
                        if (r_op == OP_RELEASE) begin
                            r_rel <= key_hit;
                            r_val <= rd_v && !key_hit;
                            {r_ea, r_es, r_et} <= (rd_v && !key_hit) ? {rd_a, rd_s, rd_t} : '0;
                        end else if (do_rec) begin
                            r_rec <= 1'b1;
                            r_val <= 1'b1;
                            {r_ea, r_es, r_et} <= {r_addr, r_size, r_stamp};
                        end else begin
                            r_val <= rd_v;
                            {r_ea, r_es, r_et} <= rd_v ? {rd_a, rd_s, rd_t} : '0;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out <= {1'b0, r_et, r_es, r_ea, r_val,
                                  OUT_SLOT_W'(r_slot), r_rel, r_rec};
                        r_state <= S_IDLE;
                    end
                end
                S_CLR: begin
                    r_clr_cnt <= r_clr_cnt + SLOT_BITS'(1);
                    if (r_clr_cnt == SLOT_BITS'(SLOTS - 1)) begin
                        r_state  <= r_clr_op ? S_FIN : S_IDLE;
                        r_clr_op <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/att_checker.sv =====
`timescale 1ns / 1ps
`include "allocation_tracking_table_top_assert.svh"
module att_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [271:0] s_axis_tdata,
    input logic [2:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [207:0] m_axis_tdata
);
    `ATT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result beat changed while stalled")
    `ATT_ASSERT_NOW(a_empty_zero, m_axis_tvalid && !m_axis_tdata[14], m_axis_tdata[207:15] == '0, "empty slot reported with data")
    `ATT_ASSERT_NOW(a_rec_valid, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[14] && !m_axis_tdata[1] || m_axis_tdata[14], "recorded without entry")
    `ATT_ASSERT_NEXT(a_one_at_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat taken while busy")
endmodule

bind allocation_tracking_table_top att_checker u_att_checker (.*);
